@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTP header parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

// Check that a consequent holds whenever the antecedent holds.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

@@ hw/rtl/rhp_pkg.sv @@
// ----------------------------------------------------------------------------
// rhp_pkg
// Section and status codes and the item type passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package rhp_pkg;

   typedef logic [2:0] section_type;
   localparam section_type SEC_HEADER  = 3'd0;
   localparam section_type SEC_CSRC    = 3'd1;
   localparam section_type SEC_EXTHDR  = 3'd2;
   localparam section_type SEC_EXTDATA = 3'd3;
   localparam section_type SEC_PAYLOAD = 3'd4;

   typedef logic [2:0] status_type;
   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_NOT_RTP   = 3'd1;
   localparam status_type ST_CSRC_CUT  = 3'd2;
   localparam status_type ST_EXT_CUT   = 3'd3;
   localparam status_type ST_BAD_PAD   = 3'd4;

   localparam int unsigned POS_W      = 4;
   localparam int unsigned EXT_REM_W  = 18;
   localparam int unsigned PLEN_W     = 12;
   localparam logic [POS_W-1:0] HDR_LAST_IDX = 4'd11;
   localparam logic [1:0] RTP_VERSION = 2'd2;

   // Classified byte: section tag, data byte, last flag, byte position within the
   // fixed header or extension header, and the end-of-packet class seen by the front.
   typedef struct packed {
      section_type      section;
      logic [7:0]       data;
      logic             last;
      logic [POS_W-1:0] pos;
      status_type       end_class;
   } rhp_item_type;

endpackage

`default_nettype wire

@@ hw/rtl/rhp_front.sv @@
// ----------------------------------------------------------------------------
// rhp_front
// Section tracker: tags each accepted byte with its packet section.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rhp_front import rhp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire logic [7:0]   data_byte,
   input  wire logic         last_byte,
   output rhp_item_type      item
);

   section_type            sec_ff, sec_in, tag;
   logic [POS_W-1:0]       idx_ff, idx_in, pos;
   logic [EXT_REM_W-1:0]   rem_ff, rem_in, rem_dec;
   logic                   ext_ff, ext_in;
   logic [3:0]             csrc_ff, csrc_in;
   section_type            after_csrc;
   status_type             end_class;

   always_comb begin
      after_csrc = ext_ff ? SEC_EXTHDR : SEC_PAYLOAD;
      rem_dec    = (rem_ff != '0) ? rem_ff - EXT_REM_W'(1) : rem_ff;
      sec_in     = sec_ff;
      idx_in     = idx_ff;
      rem_in     = rem_ff;
      ext_in     = ext_ff;
      csrc_in    = csrc_ff;
      tag        = sec_ff;
      pos        = idx_ff;
      unique case (sec_ff)
         SEC_HEADER: begin
            if (idx_ff == '0) begin
               ext_in  = data_byte[4];
               csrc_in = data_byte[3:0];
            end
            if (idx_ff == HDR_LAST_IDX) begin
               if (csrc_ff != '0) begin
                  sec_in = SEC_CSRC;
                  rem_in = {{(EXT_REM_W-6){1'b0}}, csrc_ff, 2'b00};
               end else begin
                  sec_in = after_csrc;
                  rem_in = '0;
               end
            end else begin
               idx_in = idx_ff + POS_W'(1);
            end
         end
         SEC_CSRC: begin
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               sec_in = after_csrc;
            end
         end
         SEC_EXTHDR: begin
            pos = {2'b00, rem_ff[1:0]};
            unique case (rem_ff[1:0])
               2'd0: rem_in = EXT_REM_W'(1);
               2'd1: rem_in = EXT_REM_W'(2);
               2'd2: rem_in = {{(EXT_REM_W-10){1'b0}}, data_byte, 2'b11};
               default: begin
                  rem_in = {rem_ff[9:2], data_byte, 2'b00};
                  sec_in = (rem_in != '0) ? SEC_EXTDATA : SEC_PAYLOAD;
               end
            endcase
         end
         SEC_EXTDATA: begin
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               sec_in = SEC_PAYLOAD;
            end
         end
         default: begin
            tag    = SEC_PAYLOAD;
            sec_in = SEC_PAYLOAD;
         end
      endcase

      unique case (sec_in)
         SEC_HEADER:  end_class = ST_NOT_RTP;
         SEC_CSRC:    end_class = ST_CSRC_CUT;
         SEC_EXTHDR,
         SEC_EXTDATA: end_class = ST_EXT_CUT;
         default:     end_class = ST_OK;
      endcase

      // drop all per-packet state after the last byte
      if (last_byte) begin
         sec_in  = SEC_HEADER;
         idx_in  = '0;
         rem_in  = '0;
         ext_in  = 1'b0;
         csrc_in = '0;
      end
   end

   assign item.section   = tag;
   assign item.data      = data_byte;
   assign item.last      = last_byte;
   assign item.pos       = pos;
   assign item.end_class = end_class;

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff  <= SEC_HEADER;
         idx_ff  <= '0;
         rem_ff  <= '0;
         ext_ff  <= 1'b0;
         csrc_ff <= '0;
      end else if (push) begin
         sec_ff  <= sec_in;
         idx_ff  <= idx_in;
         rem_ff  <= rem_in;
         ext_ff  <= ext_in;
         csrc_ff <= csrc_in;
      end
   end

   `ASSERT_ALWAYS(a_front_idx_range, clock, reset, idx_ff <= HDR_LAST_IDX)

endmodule

`default_nettype wire

@@ hw/rtl/rhp_queue.sv @@
// ----------------------------------------------------------------------------
// rhp_queue
// Two-entry queue between the section tracker and the field extractor.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rhp_queue import rhp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire rhp_item_type push_item,
   output logic              not_full,
   input  wire logic         pop,
   output logic              not_empty,
   output rhp_item_type      head
);

   localparam logic [1:0] DEPTH = 2'd2;

   rhp_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   assign not_full  = (count_ff != DEPTH);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `ASSERT_IMPLIES(a_queue_push_room, clock, reset, push, count_ff != DEPTH)
   `ASSERT_IMPLIES(a_queue_pop_data, clock, reset, pop, count_ff != 2'd0)

endmodule

`default_nettype wire

@@ hw/rtl/rhp_back.sv @@
// ----------------------------------------------------------------------------
// rhp_back
// Field extractor: latches header fields, counts payload, reports status.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rhp_back import rhp_pkg::*; #(
   parameter int unsigned MAX_PACKET_BYTES = 2048
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_valid,
   input  wire rhp_item_type q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_section,
   output logic [7:0]        rsp_byte_out,
   output logic              rsp_end_of_packet,
   output logic [2:0]        rsp_status,
   output logic [3:0]        rsp_csrc_total,
   output logic              rsp_marker_bit,
   output logic [6:0]        rsp_payload_kind,
   output logic [15:0]       rsp_seq_number,
   output logic [31:0]       rsp_time_stamp,
   output logic [31:0]       rsp_source_id,
   output logic [15:0]       rsp_ext_profile,
   output logic [PLEN_W-1:0] rsp_payload_length
);

   localparam int unsigned CNT_W = $clog2(MAX_PACKET_BYTES + 1);
   localparam int unsigned CMP_W = (CNT_W > PLEN_W) ? CNT_W : PLEN_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

   // packet state
   logic [1:0]       ver_ff, ver_in;
   logic             pad_ff, pad_in;
   logic [3:0]       csrc_ff, csrc_in;
   logic             mark_ff, mark_in;
   logic [6:0]       ptype_ff, ptype_in;
   logic [15:0]      seq_ff, seq_in;
   logic [31:0]      stamp_ff, stamp_in;
   logic [31:0]      src_ff, src_in;
   logic [15:0]      prof_ff, prof_in;
   logic [CNT_W-1:0] pcnt_ff, pcnt_in;
   logic [7:0]       lastv_ff, lastv_in;

   // result register
   logic             valid_ff, valid_in;
   section_type      sec_ff;
   logic [7:0]       byte_ff;
   logic             eop_ff;
   status_type       status_ff, status_in;
   logic [3:0]       csrc_out_ff;
   logic             mark_out_ff;
   logic [6:0]       ptype_out_ff;
   logic [15:0]      seq_out_ff;
   logic [31:0]      stamp_out_ff;
   logic [31:0]      src_out_ff;
   logic [15:0]      prof_out_ff;
   logic [PLEN_W-1:0] plen_ff, plen_in;

   logic [CMP_W-1:0] pcnt_ext, lastv_ext, plen_wide;
   logic [7:0]       b;

   assign b        = q_item.data;
   assign q_pop    = q_valid && (!valid_ff || rsp_ready);
   assign valid_in = q_pop ? 1'b1 : (valid_ff && !rsp_ready);

   always_comb begin
      ver_in   = ver_ff;
      pad_in   = pad_ff;
      csrc_in  = csrc_ff;
      mark_in  = mark_ff;
      ptype_in = ptype_ff;
      seq_in   = seq_ff;
      stamp_in = stamp_ff;
      src_in   = src_ff;
      prof_in  = prof_ff;
      pcnt_in  = pcnt_ff;
      lastv_in = lastv_ff;
      unique case (q_item.section)
         SEC_HEADER: begin
            priority if (q_item.pos == 4'd0) begin
               ver_in  = b[7:6];
               pad_in  = b[5];
               csrc_in = b[3:0];
            end else if (q_item.pos == 4'd1) begin
               mark_in  = b[7];
               ptype_in = b[6:0];
            end else if (q_item.pos < 4'd4) begin
               seq_in = {seq_ff[7:0], b};
            end else if (q_item.pos < 4'd8) begin
               stamp_in = {stamp_ff[23:0], b};
            end else begin
               src_in = {src_ff[23:0], b};
            end
         end
         SEC_EXTHDR: begin
            if (q_item.pos == 4'd0) begin
               prof_in = {b, 8'h00};
            end else if (q_item.pos == 4'd1) begin
               prof_in = {prof_ff[15:8], b};
            end
         end
         SEC_PAYLOAD: begin
            if (pcnt_ff < CNT_MAX) begin
               pcnt_in = pcnt_ff + CNT_W'(1);
            end
            lastv_in = b;
         end
         default: begin
         end
      endcase

      pcnt_ext  = CMP_W'(pcnt_in);
      lastv_ext = CMP_W'(lastv_in);
      plen_wide = pcnt_ext - lastv_ext;
      status_in = ST_OK;
      plen_in   = '0;
      if (q_item.last) begin
         priority if (q_item.end_class == ST_NOT_RTP || ver_in != RTP_VERSION) begin
            status_in = ST_NOT_RTP;
         end else if (q_item.end_class != ST_OK) begin
            status_in = q_item.end_class;
         end else if (pad_in && pcnt_in != '0) begin
            if (lastv_in == 8'd0 || lastv_ext > pcnt_ext) begin
               status_in = ST_BAD_PAD;
            end else begin
               plen_in = plen_wide[PLEN_W-1:0];
            end
         end else begin
            plen_in = pcnt_ext[PLEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         sec_ff       <= q_item.section;
         byte_ff      <= b;
         eop_ff       <= q_item.last;
         status_ff    <= status_in;
         csrc_out_ff  <= csrc_in;
         mark_out_ff  <= mark_in;
         ptype_out_ff <= ptype_in;
         seq_out_ff   <= seq_in;
         stamp_out_ff <= stamp_in;
         src_out_ff   <= src_in;
         prof_out_ff  <= prof_in;
         plen_ff      <= plen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ver_ff   <= '0;
         pad_ff   <= 1'b0;
         csrc_ff  <= '0;
         mark_ff  <= 1'b0;
         ptype_ff <= '0;
         seq_ff   <= '0;
         stamp_ff <= '0;
         src_ff   <= '0;
         prof_ff  <= '0;
         pcnt_ff  <= '0;
         lastv_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (q_pop) begin
            if (q_item.last) begin
               ver_ff   <= '0;
               pad_ff   <= 1'b0;
               csrc_ff  <= '0;
               mark_ff  <= 1'b0;
               ptype_ff <= '0;
               seq_ff   <= '0;
               stamp_ff <= '0;
               src_ff   <= '0;
               prof_ff  <= '0;
               pcnt_ff  <= '0;
               lastv_ff <= '0;
            end else begin
               ver_ff   <= ver_in;
               pad_ff   <= pad_in;
               csrc_ff  <= csrc_in;
               mark_ff  <= mark_in;
               ptype_ff <= ptype_in;
               seq_ff   <= seq_in;
               stamp_ff <= stamp_in;
               src_ff   <= src_in;
               prof_ff  <= prof_in;
               pcnt_ff  <= pcnt_in;
               lastv_ff <= lastv_in;
            end
         end
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_section        = sec_ff;
   assign rsp_byte_out       = byte_ff;
   assign rsp_end_of_packet  = eop_ff;
   assign rsp_status         = status_ff;
   assign rsp_csrc_total     = csrc_out_ff;
   assign rsp_marker_bit     = mark_out_ff;
   assign rsp_payload_kind   = ptype_out_ff;
   assign rsp_seq_number     = seq_out_ff;
   assign rsp_time_stamp     = stamp_out_ff;
   assign rsp_source_id      = src_out_ff;
   assign rsp_ext_profile    = prof_out_ff;
   assign rsp_payload_length = plen_ff;

   `ASSERT_IMPLIES(a_back_status_eop, clock, reset, valid_ff && (status_ff != ST_OK), eop_ff)
   `ASSERT_IMPLIES(a_back_plen_ok, clock, reset, valid_ff && (plen_ff != '0), eop_ff && (status_ff == ST_OK))

endmodule

`default_nettype wire

@@ hw/rtl/rtp_header_parser.sv @@
// ----------------------------------------------------------------------------
// rtp_header_parser
// Byte-serial RTP header parser: section tagging, field capture, status.
// ----------------------------------------------------------------------------
// Flow: a req byte passes the queue entry and then the result register
//   before its result can be taken on rsp.
// Throughput: one byte per cycle sustained while rsp_ready holds, set by the
//   one-byte-per-cycle section tracker feeding a two-entry queue.
// Reset: synchronous, active high; clears section state, latched fields,
//   the queue and the result valid. No clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_header_parser import rhp_pkg::*; #(
   parameter int unsigned MAX_PACKET_BYTES = 2048
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // input byte channel
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_data_byte,
   input  wire logic         req_last_byte,
   // result channel
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic [2:0]        rsp_section,
   output logic [7:0]        rsp_byte_out,
   output logic              rsp_end_of_packet,
   output logic [2:0]        rsp_status,
   output logic [3:0]        rsp_csrc_total,
   output logic              rsp_marker_bit,
   output logic [6:0]        rsp_payload_kind,
   output logic [15:0]       rsp_seq_number,
   output logic [31:0]       rsp_time_stamp,
   output logic [31:0]       rsp_source_id,
   output logic [15:0]       rsp_ext_profile,
   output logic [11:0]       rsp_payload_length
);

   rhp_item_type front_item;
   rhp_item_type q_head;
   logic         q_not_full;
   logic         q_not_empty;
   logic         q_pop;
   logic         push;

   // The front takes a byte whenever the queue has room; the transfer itself
   // advances the section tracker.
   assign req_ready = q_not_full;
   assign push      = req_valid && q_not_full;

   // Front: classify each byte into header, CSRC list, extension header,
   // extension data or payload, and note how the packet would end here.
   rhp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .item      (front_item)
   );

   // Queue: decouple the tracker from a stalled result channel so bytes keep
   // flowing while a finished result waits, until its two entries are full.
   rhp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // Back: latch header fields, count payload, resolve status and payload
   // length on the last byte, and hold the result until it is taken.
   rhp_back #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_not_empty),
      .q_item             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_section        (rsp_section),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_end_of_packet  (rsp_end_of_packet),
      .rsp_status         (rsp_status),
      .rsp_csrc_total     (rsp_csrc_total),
      .rsp_marker_bit     (rsp_marker_bit),
      .rsp_payload_kind   (rsp_payload_kind),
      .rsp_seq_number     (rsp_seq_number),
      .rsp_time_stamp     (rsp_time_stamp),
      .rsp_source_id      (rsp_source_id),
      .rsp_ext_profile    (rsp_ext_profile),
      .rsp_payload_length (rsp_payload_length)
   );

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte-serial RTP header parser. Packets of
// random content (well-formed, cut short, wrong version, bad padding, noise
// and one long packet) stream through valid/ready with random gaps on
// both sides; a scoreboard predicts every result item and checks it.
// ----------------------------------------------------------------------------
module tb_top;
   import rhp_pkg::*;

   localparam int unsigned PKT_LIMIT     = 2048;
   localparam int unsigned RANDOM_BYTES  = 1050;
   localparam int unsigned LONG_PAYLOAD  = 300;
   localparam int unsigned SETTLE_CYCLES = 10;

   // one result item as it leaves the parser
   typedef struct packed {
      section_type section;
      logic [7:0]  byte_out;
      logic        eop;
      status_type  status;
      logic [3:0]  csrc_total;
      logic        marker;
      logic [6:0]  kind;
      logic [15:0] seq;
      logic [31:0] stamp;
      logic [31:0] source;
      logic [15:0] profile;
      logic [11:0] plen;
   } rtp_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: tracks the parse of the current packet and holds the
   // result items still owed by the block, oldest first.
   // -------------------------------------------------------------------------
   class rtp_scoreboard;
      rtp_result_type owed_q[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned status_seen[5];

      section_type sec;
      logic [11:0] hdr_cnt;
      logic [17:0] remain;
      logic [1:0]  ver;
      logic        pad_bit;
      logic        ext_bit;
      logic [3:0]  cc;
      logic        mark;
      logic [6:0]  ptype;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [31:0] ssrc;
      logic [15:0] prof;
      logic [11:0] pay_cnt;
      logic [7:0]  pay_last;

      function new();
         errors  = 0;
         checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         sec      = SEC_HEADER;
         hdr_cnt  = '0;
         remain   = '0;
         ver      = '0;
         pad_bit  = 1'b0;
         ext_bit  = 1'b0;
         cc       = '0;
         mark     = 1'b0;
         ptype    = '0;
         seq      = '0;
         ts       = '0;
         ssrc     = '0;
         prof     = '0;
         pay_cnt  = '0;
         pay_last = '0;
      endfunction

      // leave the fixed header or CSRC list
      function void after_csrc();
         if (ext_bit) begin
            sec    = SEC_EXTHDR;
            remain = '0;
         end else begin
            sec = SEC_PAYLOAD;
         end
      endfunction

      // predict the result of one transferred input byte
      function void note_input(logic [7:0] b, logic last);
         rtp_result_type r;
         section_type tag;
         status_type  st;
         logic [11:0] plen;
         logic [11:0] idx;
         logic [15:0] words;
         tag  = sec;
         st   = ST_OK;
         plen = '0;
         case (sec)
            SEC_HEADER: begin
               idx = hdr_cnt;
               if (idx == 0) begin
                  ver     = b[7:6];
                  pad_bit = b[5];
                  ext_bit = b[4];
                  cc      = b[3:0];
               end else if (idx == 1) begin
                  mark  = b[7];
                  ptype = b[6:0];
               end else if (idx < 4) begin
                  seq = {seq[7:0], b};
               end else if (idx < 8) begin
                  ts = {ts[23:0], b};
               end else begin
                  ssrc = {ssrc[23:0], b};
               end
               if (hdr_cnt < PKT_LIMIT) hdr_cnt++;
               if (idx == 11) begin
                  if (cc != 0) begin
                     sec    = SEC_CSRC;
                     remain = 18'({cc, 2'b00});
                  end else begin
                     after_csrc();
                  end
               end
            end
            SEC_CSRC: begin
               if (remain > 0) remain--;
               if (remain == 0) after_csrc();
            end
            SEC_EXTHDR: begin
               case (remain[1:0])
                  2'd0: begin
                     prof   = {b, 8'h00};
                     remain = 18'd1;
                  end
                  2'd1: begin
                     prof   = {prof[15:8], b};
                     remain = 18'd2;
                  end
                  2'd2: remain = 18'({b, 2'b11});
                  default: begin
                     words  = {remain[9:2], b};
                     remain = {words, 2'b00};
                     sec    = (remain != 0) ? SEC_EXTDATA : SEC_PAYLOAD;
                  end
               endcase
            end
            SEC_EXTDATA: begin
               if (remain > 0) remain--;
               if (remain == 0) sec = SEC_PAYLOAD;
            end
            default: begin
               tag = SEC_PAYLOAD;
               sec = SEC_PAYLOAD;
               if (pay_cnt < PKT_LIMIT) pay_cnt++;
               pay_last = b;
            end
         endcase

         if (last) begin
            if (sec == SEC_HEADER || ver != RTP_VERSION) begin
               st = ST_NOT_RTP;
            end else if (sec == SEC_CSRC) begin
               st = ST_CSRC_CUT;
            end else if (sec == SEC_EXTHDR || sec == SEC_EXTDATA) begin
               st = ST_EXT_CUT;
            end else if (pad_bit && pay_cnt > 0) begin
               if (pay_last == 0 || 12'(pay_last) > pay_cnt) st = ST_BAD_PAD;
               else plen = pay_cnt - 12'(pay_last);
            end else begin
               plen = pay_cnt;
            end
         end

         r.section    = tag;
         r.byte_out   = b;
         r.eop        = last;
         r.status     = st;
         r.csrc_total = cc;
         r.marker     = mark;
         r.kind       = ptype;
         r.seq        = seq;
         r.stamp      = ts;
         r.source     = ssrc;
         r.profile    = prof;
         r.plen       = plen;
         owed_q.push_back(r);
         if (last) begin
            status_seen[st]++;
            clear_packet();
         end
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // check one transferred result against the oldest prediction
      function void check_result(rtp_result_type got);
         rtp_result_type e;
         if (owed_q.size() == 0) begin
            $error("result with no prediction waiting: byte %0h", got.byte_out);
            errors++;
            return;
         end
         e = owed_q.pop_front();
         checked++;
         compare_field("section", 32'(e.section), 32'(got.section));
         compare_field("byte_out", 32'(e.byte_out), 32'(got.byte_out));
         compare_field("end_of_packet", 32'(e.eop), 32'(got.eop));
         compare_field("status", 32'(e.status), 32'(got.status));
         compare_field("csrc_total", 32'(e.csrc_total), 32'(got.csrc_total));
         compare_field("marker_bit", 32'(e.marker), 32'(got.marker));
         compare_field("payload_kind", 32'(e.kind), 32'(got.kind));
         compare_field("seq_number", 32'(e.seq), 32'(got.seq));
         compare_field("time_stamp", e.stamp, got.stamp);
         compare_field("source_id", e.source, got.source);
         compare_field("ext_profile", 32'(e.profile), 32'(got.profile));
         compare_field("payload_length", 32'(e.plen), 32'(got.plen));
      endfunction

      function int unsigned pending();
         return owed_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_section;
   logic [7:0]  rsp_byte_out;
   logic        rsp_end_of_packet;
   logic [2:0]  rsp_status;
   logic [3:0]  rsp_csrc_total;
   logic        rsp_marker_bit;
   logic [6:0]  rsp_payload_kind;
   logic [15:0] rsp_seq_number;
   logic [31:0] rsp_time_stamp;
   logic [31:0] rsp_source_id;
   logic [15:0] rsp_ext_profile;
   logic [11:0] rsp_payload_length;

   rtp_header_parser #(
      .MAX_PACKET_BYTES (PKT_LIMIT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_section        (rsp_section),
      .rsp_byte_out       (rsp_byte_out),
      .rsp_end_of_packet  (rsp_end_of_packet),
      .rsp_status         (rsp_status),
      .rsp_csrc_total     (rsp_csrc_total),
      .rsp_marker_bit     (rsp_marker_bit),
      .rsp_payload_kind   (rsp_payload_kind),
      .rsp_seq_number     (rsp_seq_number),
      .rsp_time_stamp     (rsp_time_stamp),
      .rsp_source_id      (rsp_source_id),
      .rsp_ext_profile    (rsp_ext_profile),
      .rsp_payload_length (rsp_payload_length)
   );

   rtp_scoreboard sb = new();

   logic [7:0]  pkt_q[$];     // bytes of the packet being sent
   logic        steady = 1'b0; // suppress idling on both sides
   int unsigned bytes_sent;
   int unsigned packets_sent;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random gap length: mostly none or short, now and then long.
   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Transfer one byte; hold valid and payload until ready is seen.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = steady ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_input(b, last);
      bytes_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
      packets_sent++;
   endtask

   // Drop valid and hold off until every predicted result has come back.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic append_random(input int unsigned n);
      repeat (n) pkt_q.push_back(8'($urandom));
   endtask

   // Build one random packet into pkt_q. Most are well-formed RTP with
   // random content; the rest are truncated, wrong-version, short or noise.
   task automatic build_packet();
      int unsigned pick;
      int unsigned cc;
      int unsigned n;
      int unsigned r;
      int unsigned pad;
      int unsigned cut;
      int unsigned words;
      logic        pad_bit;
      logic        ext_bit;
      logic [1:0]  ver;
      pkt_q.delete();
      pick = $urandom_range(0, 99);
      if (pick >= 94) begin
         append_random($urandom_range(1, 30));
         return;
      end
      if (pick >= 88) begin
         append_random($urandom_range(1, 11));
         return;
      end
      ver = RTP_VERSION;
      if (pick >= 80) begin
         do ver = 2'($urandom); while (ver == RTP_VERSION);
      end
      pad_bit = 1'($urandom);
      ext_bit = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 9);
      cc = (r == 0) ? 15 : (r < 7) ? $urandom_range(0, 2) : $urandom_range(0, 15);
      pkt_q.push_back({ver, pad_bit, ext_bit, 4'(cc)});
      append_random(11 + cc * 4);
      if (ext_bit) begin
         append_random(2);
         // an oversized extension length: end the packet inside its data
         if ($urandom_range(0, 9) == 0) begin
            words = $urandom_range(256, 65535);
            pkt_q.push_back(words[15:8]);
            pkt_q.push_back(words[7:0]);
            append_random($urandom_range(0, 8));
            return;
         end
         words = $urandom_range(0, 3);
         pkt_q.push_back(words[15:8]);
         pkt_q.push_back(words[7:0]);
         append_random(words * 4);
      end
      n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 24) : $urandom_range(25, 80);
      append_random(n);
      if (pad_bit && n > 0) begin
         r = $urandom_range(0, 99);
         if (r < 70) pad = $urandom_range(1, (n < 255) ? n : 255);
         else if (r < 85 || n >= 255) pad = 0;
         else pad = $urandom_range(n + 1, 255);
         pkt_q[pkt_q.size() - 1] = 8'(pad);
      end
      if (pick >= 70 && pick < 80 && pkt_q.size() > 1) begin
         cut = $urandom_range(1, pkt_q.size() - 1);
         while (pkt_q.size() > cut) void'(pkt_q.pop_back());
      end
   endtask

   // Receiver: ready toggles with random stalls, none while steady.
   initial begin
      int unsigned gap;
      rsp_ready <= 1'b0;
      forever begin
         gap = steady ? 0 : idle_len();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Monitor: check every transferred result.
   always @(posedge clock) begin
      rtp_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.section    = rsp_section;
         got.byte_out   = rsp_byte_out;
         got.eop        = rsp_end_of_packet;
         got.status     = rsp_status;
         got.csrc_total = rsp_csrc_total;
         got.marker     = rsp_marker_bit;
         got.kind       = rsp_payload_kind;
         got.seq        = rsp_seq_number;
         got.stamp      = rsp_time_stamp;
         got.source     = rsp_source_id;
         got.profile    = rsp_ext_profile;
         got.plen       = rsp_payload_length;
         sb.check_result(got);
      end
   end

   // Main sequence
   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      steady        = 1'b0;
      bytes_sent    = 0;
      packets_sent  = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: one-byte packet, cut inside the fixed header
      pkt_q = '{8'hFF};
      send_packet();
      // full header only, fields after the first byte at their maximum, no CSRC,
      // no extension, padding set but payload empty
      pkt_q = '{8'hA0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_packet();
      // full header with the wrong version and all fields zero
      pkt_q = '{8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_packet();
      drain();

      // random packets
      while (bytes_sent < RANDOM_BYTES) begin
         steady = ($urandom_range(0, 4) == 0);
         build_packet();
         send_packet();
         if ($urandom_range(0, 19) == 0) drain();
      end

      // long packet: payload well past the random range, valid padding at the end
      steady = 1'b0;
      pkt_q.delete();
      pkt_q.push_back({RTP_VERSION, 1'b1, 1'b0, 4'd0});
      append_random(11 + LONG_PAYLOAD);
      pkt_q[pkt_q.size() - 1] = 8'($urandom_range(1, 255));
      send_packet();

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d packets, %0d bytes, %0d results checked.",
               packets_sent, bytes_sent, sb.checked);
      $display("End status: ok %0d, not rtp %0d, csrc cut %0d, ext cut %0d, bad pad %0d",
               sb.status_seen[ST_OK], sb.status_seen[ST_NOT_RTP],
               sb.status_seen[ST_CSRC_CUT], sb.status_seen[ST_EXT_CUT],
               sb.status_seen[ST_BAD_PAD]);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #25_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
